[rtl/core/nee_pkg.sv]
package nee_pkg;

    // widths and defaults
    localparam int DATA_W         = 32;
    localparam int CNT_W          = 5;
    localparam int NEST_DEPTH_DEF = 8;

    // token kinds
    localparam logic [2:0] KIND_NUMBER   = 3'd0;
    localparam logic [2:0] KIND_OPERATOR = 3'd1;
    localparam logic [2:0] KIND_OPEN     = 3'd2;
    localparam logic [2:0] KIND_CLOSE    = 3'd3;
    localparam logic [2:0] KIND_END      = 3'd4;

    // ascii operator characters
    localparam logic [7:0] CH_ADD = 8'h2B;
    localparam logic [7:0] CH_SUB = 8'h2D;
    localparam logic [7:0] CH_MUL = 8'h2A;
    localparam logic [7:0] CH_DIV = 8'h2F;
    localparam logic [7:0] CH_MOD = 8'h25;
    localparam logic [7:0] CH_AND = 8'h26;
    localparam logic [7:0] CH_OR  = 8'h7C;
    localparam logic [7:0] CH_SHL = 8'h3C;
    localparam logic [7:0] CH_SHR = 8'h3E;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_ADD,
        OP_SUB,
        OP_MUL,
        OP_DIV,
        OP_MOD,
        OP_AND,
        OP_OR,
        OP_SHL,
        OP_SHR,
        OP_KEEP
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK,
        STATUS_OVERFLOW,
        STATUS_SEQUENCE,
        STATUS_EMPTY
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CALC,
        ST_WB,
        ST_POP,
        ST_FOLD
    } state_t;

    typedef struct packed {
        logic [2:0]        token_kind;
        logic [DATA_W-1:0] token_value;
        logic [7:0]        opcode;
    } token_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic [1:0]        status_code;
        logic              divide_by_zero;
    } result_t;

    typedef struct packed {
        logic [DATA_W-1:0] acc;
        op_t               op;
    } frame_t;

    // operator character to internal code, anything unknown keeps the value
    function automatic op_t decode_op(input logic [7:0] ch);
        op_t op;
        unique case (ch)
            CH_ADD:  op = OP_ADD;
            CH_SUB:  op = OP_SUB;
            CH_MUL:  op = OP_MUL;
            CH_DIV:  op = OP_DIV;
            CH_MOD:  op = OP_MOD;
            CH_AND:  op = OP_AND;
            CH_OR:   op = OP_OR;
            CH_SHL:  op = OP_SHL;
            CH_SHR:  op = OP_SHR;
            default: op = OP_KEEP;
        endcase
        return op;
    endfunction

    // operations that go through the bit-serial unit (division and modulo only by a nonzero divisor)
    function automatic logic op_is_serial(input op_t op, input logic [DATA_W-1:0] b);
        logic serial;
        unique case (op)
            OP_ADD, OP_SUB, OP_MUL, OP_AND, OP_OR, OP_SHL, OP_SHR: serial = 1'b1;
            OP_DIV, OP_MOD: serial = (b != '0);
            default: serial = 1'b0;
        endcase
        return serial;
    endfunction

    // first error wins
    function automatic status_t note_status(input status_t cur, input status_t code);
        return (cur == STATUS_OK) ? code : cur;
    endfunction

endpackage

[rtl/core/nested_expression_evaluator_core.sv]
// left-to-right 32-bit unsigned expression evaluator
//
// token channel: token_valid / token_ready carry one pre-parsed request
// (number, operator, open group, close group, end). result channel:
// result_valid / result_ready carry one result per end request, with the
// value, a status code and a sticky divide-by-zero flag.
// operator and open requests finish in the idle state; a number whose
// arithmetic operator is not a division by zero runs through the one
// bit-serial unit, one result bit (or one quotient bit, or one shift step)
// per cycle, then a write-back. a close whose operator is arithmetic adds
// a stack read before that; a close with no operator to apply takes only
// the stack read. an end request folds each open group in turn the same
// way, then loads the result register.
// token_ready is high only while no request is in work.
// the result register holds the result until taken; a following
// expression can be entered meanwhile, but its end waits for the register.
// reset empties the group stack, clears the status and drops any held
// result; the stack memory itself is not cleared.
module nested_expression_evaluator_core #(
    parameter int NEST_DEPTH = nee_pkg::NEST_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             token_valid,
    output logic             token_ready,
    input  nee_pkg::token_t  token,
    output logic             result_valid,
    input  logic             result_ready,
    output nee_pkg::result_t result
);
    import nee_pkg::*;

    localparam int LVL_W  = $clog2(NEST_DEPTH + 1);
    localparam int ADDR_W = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam logic [LVL_W-1:0] LVL_FULL = LVL_W'(NEST_DEPTH);
    localparam logic [CNT_W-1:0] CNT_LAST = '1;

    // control state
    state_t            state_reg, state_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    op_t               pend_reg, pend_next;
    logic              expect_reg, expect_next;
    logic              have_reg, have_next;
    logic [LVL_W-1:0]  level_reg, level_next;
    status_t           sticky_reg, sticky_next;
    logic              divz_reg, divz_next;
    logic              folding_reg, folding_next;
    logic              result_valid_reg, result_valid_next;

    // serial unit and payload
    op_t               calc_op_reg, calc_op_next;
    logic [DATA_W-1:0] opa_reg, opa_next;
    logic [DATA_W-1:0] opb_reg, opb_next;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic              carry_reg, carry_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    result_t           result_reg, result_next;

    // group stack
    frame_t            stack_mem [NEST_DEPTH];
    frame_t            rd_data_reg;

    // control signals
    logic              accept;
    logic              rd_en;
    logic              wr_en;
    logic              emit;
    logic [LVL_W-1:0]  lvl_dec;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic              start_en;
    logic [DATA_W-1:0] start_a;
    logic [DATA_W-1:0] start_b;
    op_t               start_op;
    logic              start_serial;

    // serial step helpers
    logic              sum_bit;
    logic              sum_carry;
    logic [DATA_W:0]   div_trial;
    logic [DATA_W:0]   div_diff;
    logic              div_fit;

    assign lvl_dec = level_reg - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (token.token_kind == KIND_NUMBER && expect_reg
                        && op_is_serial(pend_reg, token.token_value))
                        state_next = ST_CALC;
                    else if (token.token_kind == KIND_CLOSE && level_reg != '0)
                        state_next = ST_POP;
                    else if (token.token_kind == KIND_END)
                        state_next = ST_FOLD;
                end
            end
            ST_CALC:
            begin
                if (cnt_reg == CNT_LAST)
                    state_next = ST_WB;
            end
            ST_WB:
            begin
                state_next = folding_reg ? ST_FOLD : ST_IDLE;
            end
            ST_POP:
            begin
                if (op_is_serial(rd_data_reg.op, acc_reg))
                    state_next = ST_CALC;
                else
                    state_next = folding_reg ? ST_FOLD : ST_IDLE;
            end
            ST_FOLD:
            begin
                if (level_reg != '0)
                    state_next = ST_POP;
                else if (!result_valid_reg || result_ready)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        token_ready = (state_reg == ST_IDLE);
        accept      = token_valid && token_ready;
        rd_en       = (accept && token.token_kind == KIND_CLOSE && level_reg != '0)
                   || (state_reg == ST_FOLD && level_reg != '0);
        rd_addr     = lvl_dec[ADDR_W-1:0];
        wr_en       = accept && token.token_kind == KIND_OPEN && expect_reg
                   && level_reg != LVL_FULL;
        wr_addr     = level_reg[ADDR_W-1:0];
        emit        = (state_reg == ST_FOLD) && (level_reg == '0)
                   && (!result_valid_reg || result_ready);
        if (state_reg == ST_POP)
        begin
            start_en = 1'b1;
            start_a  = rd_data_reg.acc;
            start_op = rd_data_reg.op;
            start_b  = acc_reg;
        end
        else
        begin
            start_en = accept && token.token_kind == KIND_NUMBER && expect_reg;
            start_a  = acc_reg;
            start_op = pend_reg;
            start_b  = token.token_value;
        end
        start_serial = op_is_serial(start_op, start_b);
    end

    // serial step terms
    assign sum_bit   = opa_reg[0] ^ opb_reg[0] ^ carry_reg;
    assign sum_carry = (opa_reg[0] & opb_reg[0]) | (carry_reg & (opa_reg[0] ^ opb_reg[0]));
    assign div_trial = {rem_reg, opa_reg[DATA_W-1]};
    assign div_diff  = div_trial - {1'b0, opb_reg};
    assign div_fit   = (div_trial >= {1'b0, opb_reg});

    // datapath and token handling
    always_comb
    begin
        acc_next          = acc_reg;
        pend_next         = pend_reg;
        expect_next       = expect_reg;
        have_next         = have_reg;
        level_next        = level_reg;
        sticky_next       = sticky_reg;
        divz_next         = divz_reg;
        folding_next      = folding_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        calc_op_next      = calc_op_reg;
        opa_next          = opa_reg;
        opb_next          = opb_reg;
        res_next          = res_reg;
        rem_next          = rem_reg;
        carry_next        = carry_reg;
        cnt_next          = cnt_reg;

        if (result_valid_reg && result_ready)
            result_valid_next = 1'b0;

        // token decode
        if (accept)
        begin
            unique case (token.token_kind)
                KIND_NUMBER:
                begin
                    if (!expect_reg)
                        sticky_next = note_status(sticky_reg, STATUS_SEQUENCE);
                    else
                    begin
                        pend_next   = OP_NONE;
                        expect_next = 1'b0;
                        have_next   = 1'b1;
                    end
                end
                KIND_OPERATOR:
                begin
                    if (expect_reg)
                        sticky_next = note_status(sticky_reg, STATUS_SEQUENCE);
                    else
                    begin
                        pend_next   = decode_op(token.opcode);
                        expect_next = 1'b1;
                    end
                end
                KIND_OPEN:
                begin
                    if (!expect_reg)
                        sticky_next = note_status(sticky_reg, STATUS_SEQUENCE);
                    else if (level_reg == LVL_FULL)
                        sticky_next = note_status(sticky_reg, STATUS_OVERFLOW);
                    else
                    begin
                        level_next = level_reg + 1'b1;
                        acc_next   = '0;
                        pend_next  = OP_NONE;
                    end
                end
                KIND_CLOSE:
                begin
                    if (level_reg == '0)
                        sticky_next = note_status(sticky_reg, STATUS_SEQUENCE);
                end
                KIND_END:
                begin
                    folding_next = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        // pop one group level on a stack read
        if (rd_en)
            level_next = lvl_dec;

        if (state_reg == ST_POP)
        begin
            pend_next   = OP_NONE;
            expect_next = 1'b0;
            have_next   = 1'b1;
        end

        // combine: fast cases finish at once, the rest load the serial unit
        if (start_en)
        begin
            if (start_serial)
            begin
                calc_op_next = start_op;
                opa_next     = ((start_op == OP_SHL || start_op == OP_SHR)
                                && start_b[DATA_W-1:CNT_W] != '0) ? '0 : start_a;
                opb_next     = (start_op == OP_SUB) ? ~start_b : start_b;
                res_next     = '0;
                rem_next     = '0;
                carry_next   = (start_op == OP_SUB);
                cnt_next     = '0;
            end
            else
            begin
                priority case (start_op)
                    OP_NONE: acc_next = start_b;
                    OP_DIV:  acc_next = '1;
                    default: acc_next = start_a;
                endcase
                if (start_op == OP_DIV || start_op == OP_MOD)
                    divz_next = 1'b1;
            end
        end

        // one bit per cycle in the serial unit
        if (state_reg == ST_CALC)
        begin
            cnt_next = cnt_reg + 1'b1;
            unique case (calc_op_reg)
                OP_ADD, OP_SUB:
                begin
                    res_next   = {sum_bit, res_reg[DATA_W-1:1]};
                    carry_next = sum_carry;
                    opa_next   = opa_reg >> 1;
                    opb_next   = opb_reg >> 1;
                end
                OP_AND:
                begin
                    res_next = {opa_reg[0] & opb_reg[0], res_reg[DATA_W-1:1]};
                    opa_next = opa_reg >> 1;
                    opb_next = opb_reg >> 1;
                end
                OP_OR:
                begin
                    res_next = {opa_reg[0] | opb_reg[0], res_reg[DATA_W-1:1]};
                    opa_next = opa_reg >> 1;
                    opb_next = opb_reg >> 1;
                end
                OP_MUL:
                begin
                    if (opb_reg[0])
                        res_next = res_reg + opa_reg;
                    opa_next = opa_reg << 1;
                    opb_next = opb_reg >> 1;
                end
                OP_DIV, OP_MOD:
                begin
                    opa_next = opa_reg << 1;
                    if (div_fit)
                    begin
                        rem_next = div_diff[DATA_W-1:0];
                        res_next = {res_reg[DATA_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = div_trial[DATA_W-1:0];
                        res_next = {res_reg[DATA_W-2:0], 1'b0};
                    end
                end
                OP_SHL:
                begin
                    if (cnt_reg < opb_reg[CNT_W-1:0])
                        opa_next = opa_reg << 1;
                end
                OP_SHR:
                begin
                    if (cnt_reg < opb_reg[CNT_W-1:0])
                        opa_next = opa_reg >> 1;
                end
                default:
                begin
                end
            endcase
        end

        // write back the serial result
        if (state_reg == ST_WB)
        begin
            priority case (calc_op_reg)
                OP_MOD:         acc_next = rem_reg;
                OP_SHL, OP_SHR: acc_next = opa_reg;
                default:        acc_next = res_reg;
            endcase
        end

        // deliver the result and start a fresh expression
        if (emit)
        begin
            result_next.result_value   = acc_reg;
            result_next.status_code    = (sticky_reg == STATUS_OK && !have_reg)
                                         ? STATUS_EMPTY : sticky_reg;
            result_next.divide_by_zero = divz_reg;
            result_valid_next          = 1'b1;
            acc_next                   = '0;
            pend_next                  = OP_NONE;
            expect_next                = 1'b1;
            have_next                  = 1'b0;
            sticky_next                = STATUS_OK;
            divz_next                  = 1'b0;
            folding_next               = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            acc_reg          <= '0;
            pend_reg         <= OP_NONE;
            expect_reg       <= 1'b1;
            have_reg         <= 1'b0;
            level_reg        <= '0;
            sticky_reg       <= STATUS_OK;
            divz_reg         <= 1'b0;
            folding_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            acc_reg          <= acc_next;
            pend_reg         <= pend_next;
            expect_reg       <= expect_next;
            have_reg         <= have_next;
            level_reg        <= level_next;
            sticky_reg       <= sticky_next;
            divz_reg         <= divz_next;
            folding_reg      <= folding_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // serial unit and result payload
    always_ff @(posedge clk)
    begin
        calc_op_reg <= calc_op_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        res_reg     <= res_next;
        rem_reg     <= rem_next;
        carry_reg   <= carry_next;
        cnt_reg     <= cnt_next;
        result_reg  <= result_next;
    end

    // group stack memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[wr_addr] <= '{acc: acc_reg, op: pend_reg};
        if (rd_en)
            rd_data_reg <= stack_mem[rd_addr];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_FULL)
        else $error("group nesting level beyond stack depth");

    a_calc_len: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CALC && cnt_reg == CNT_LAST) |=> (state_reg == ST_WB))
        else $error("serial unit did not finish after full word");

    a_pop_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_POP) |-> $past(rd_en))
        else $error("pop without stack read");

    a_emit_fold: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> ($past(state_reg) == ST_FOLD && $past(level_reg) == '0))
        else $error("result delivered with groups still open");
`endif

endmodule
